@@ rtl/krt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// krt_pkg
// Shared record type, request codes and status codes of the keyed record table.
// ----------------------------------------------------------------------------
package krt_pkg;

  typedef struct packed {
    logic [15:0] key;
    logic [7:0]  score;
    logic [7:0]  age;
  } rec_t;

  localparam logic [2:0] REQ_APPEND = 3'd0;
  localparam logic [2:0] REQ_FIND   = 3'd1;
  localparam logic [2:0] REQ_REMOVE = 3'd2;
  localparam logic [2:0] REQ_MAX    = 3'd3;
  localparam logic [2:0] REQ_MIN    = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_NONE  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

endpackage
`default_nettype wire

@@ rtl/krt_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// krt_cell
// One record cell of the rotating table; takes its neighbor's record on shift.
// ----------------------------------------------------------------------------
module krt_cell (
  input  wire logic         clk,
  input  wire logic         shift,
  input  wire krt_pkg::rec_t d,
  output krt_pkg::rec_t     q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/keyed_record_table_with_delete.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_record_table_with_delete
// Table of up to DEPTH key/score/age records with append, find, remove,
// max-score and min-score requests, built as a rotating row of record cells.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Requests that fail at
// once (table full, empty table, position out of range, unknown type) answer
// in the next cycle. All others rotate the row of DEPTH cells once past the
// head cell, one cell a cycle, and then answer; a remove with remove_mode
// set rotates twice (first to pick up the last entry, then to drop it into
// the gap) before it answers. The result shows for one cycle with done high
// and cannot be held off; a new start is taken in that same cycle. remove_mode
// is written on cfg_valid & cfg_ready.
// ----------------------------------------------------------------------------
module keyed_record_table_with_delete #(
  parameter int DEPTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  req_type,
  input  wire logic [15:0] key,
  input  wire logic [7:0]  score,
  input  wire logic [7:0]  age,
  input  wire logic [2:0]  position,
  output logic             done,
  output logic [1:0]       status,
  output logic [2:0]       index,
  output logic [15:0]      found_key,
  output logic [7:0]       found_score,
  output logic [7:0]       found_age,
  output logic [3:0]       count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data
);

  localparam int SW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 3) ? CW : 3;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic            state;
  logic [SW-1:0]   step;
  logic            pass;
  logic [2:0]      req_r;
  krt_pkg::rec_t   new_rec;
  logic [2:0]      pos_r;
  logic [CW-1:0]   cnt;
  logic            mode;
  krt_pkg::rec_t   hold;
  krt_pkg::rec_t   res_rec;
  logic [SW-1:0]   res_idx;
  logic            found;

  krt_pkg::rec_t   res_rec_next;
  logic [SW-1:0]   res_idx_next;
  logic            found_next;
  logic [CW-1:0]   cnt_after;

  krt_pkg::rec_t   cell_q [DEPTH];
  krt_pkg::rec_t   head;
  krt_pkg::rec_t   second;
  krt_pkg::rec_t   wrap;
  logic            shift_en;

  logic            accept;
  logic            is_err;
  logic [1:0]      err_st;
  logic            last_step;
  logic            swap;
  logic            final_edge;
  logic            step_lt_cnt;
  logic            step1_lt_cnt;
  logic            step_eq_cnt;
  logic            step_eq_last;
  logic            step_ge_pos;
  logic            step_eq_pos;
  logic [PW-1:0]   step_p;
  logic [PW-1:0]   pos_p;
  logic [PW-1:0]   pos_in_p;
  logic [PW-1:0]   cnt_p;
  logic [SW+2:0]   idx_wide;
  logic [CW+3:0]   cnt_wide;
  logic [CW+3:0]   cnt_after_wide;

  // ring of cells: each shifts toward the head, the head wraps to the tail
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_tail
      krt_cell u_cell (.clk(clk), .shift(shift_en), .d(wrap), .q(cell_q[i]));
    end else begin : g_body
      krt_cell u_cell (.clk(clk), .shift(shift_en), .d(cell_q[i+1]), .q(cell_q[i]));
    end
  end

  assign head      = cell_q[0];
  assign second    = cell_q[1];
  assign shift_en  = (state == S_SCAN);
  assign busy      = (state == S_SCAN);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;

  assign step_p       = PW'(step);
  assign pos_p        = PW'(pos_r);
  assign pos_in_p     = PW'(position);
  assign cnt_p        = PW'(cnt);
  assign step_lt_cnt  = CW'(step) < cnt;
  assign step1_lt_cnt = (CW'(step) + CW'(1)) < cnt;
  assign step_eq_cnt  = CW'(step) == cnt;
  assign step_eq_last = (CW'(step) + CW'(1)) == cnt;
  assign step_ge_pos  = step_p >= pos_p;
  assign step_eq_pos  = step_p == pos_p;
  assign last_step    = step == SW'(DEPTH - 1);
  assign swap         = mode && (req_r == krt_pkg::REQ_REMOVE);
  assign final_edge   = (state == S_SCAN) && last_step && (!swap || pass);

  // early refusal of a request from the inputs and the fill count
  always_comb begin
    is_err = 1'b0;
    err_st = krt_pkg::ST_NONE;
    unique case (req_type) inside
      krt_pkg::REQ_APPEND: begin
        if (cnt == CW'(DEPTH)) begin
          is_err = 1'b1;
          err_st = krt_pkg::ST_FULL;
        end
      end
      krt_pkg::REQ_FIND, krt_pkg::REQ_MAX, krt_pkg::REQ_MIN: begin
        is_err = (cnt == '0);
      end
      krt_pkg::REQ_REMOVE: begin
        if (cnt == '0) begin
          is_err = 1'b1;
        end else if (pos_in_p >= cnt_p) begin
          is_err = 1'b1;
          err_st = krt_pkg::ST_RANGE;
        end
      end
      default: begin
        is_err = 1'b1;
      end
    endcase
  end

  // value entering the tail cell
  always_comb begin
    wrap = head;
    case (req_r)
      krt_pkg::REQ_APPEND: begin
        if (step_eq_cnt) begin
          wrap = new_rec;
        end
      end
      krt_pkg::REQ_REMOVE: begin
        if (!mode) begin
          // later entries move down by one
          if (step_ge_pos && step1_lt_cnt) begin
            wrap = second;
          end
        end else if (pass && step_eq_pos) begin
          wrap = hold;
        end
      end
      default: begin
      end
    endcase
  end

  // result tracking as entries pass the head
  always_comb begin
    res_rec_next = res_rec;
    res_idx_next = res_idx;
    found_next   = found;
    case (req_r)
      krt_pkg::REQ_APPEND: begin
        if (step_eq_cnt) begin
          res_rec_next = new_rec;
          res_idx_next = step;
          found_next   = 1'b1;
        end
      end
      krt_pkg::REQ_FIND: begin
        if (!found && step_lt_cnt && (head.key == new_rec.key)) begin
          res_rec_next = head;
          res_idx_next = step;
          found_next   = 1'b1;
        end
      end
      krt_pkg::REQ_REMOVE: begin
        if (!pass && step_eq_pos) begin
          res_rec_next = head;
          res_idx_next = step;
          found_next   = 1'b1;
        end
      end
      krt_pkg::REQ_MAX: begin
        // ties go to the later entry
        if (step_lt_cnt && ((step == '0) || (head.score >= res_rec.score))) begin
          res_rec_next = head;
          res_idx_next = step;
          found_next   = 1'b1;
        end
      end
      krt_pkg::REQ_MIN: begin
        if (step_lt_cnt && ((step == '0) || (head.score < res_rec.score))) begin
          res_rec_next = head;
          res_idx_next = step;
          found_next   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (req_r)
      krt_pkg::REQ_APPEND: cnt_after = cnt + CW'(1);
      krt_pkg::REQ_REMOVE: cnt_after = cnt - CW'(1);
      default:             cnt_after = cnt;
    endcase
  end

  assign idx_wide       = {3'b000, res_idx_next};
  assign cnt_wide       = {4'b0000, cnt};
  assign cnt_after_wide = {4'b0000, cnt_after};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      mode  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        mode <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req_r   <= req_type;
            new_rec <= '{key: key, score: score, age: age};
            pos_r   <= position;
            step    <= '0;
            pass    <= 1'b0;
            found   <= 1'b0;
            if (is_err) begin
              done        <= 1'b1;
              status      <= err_st;
              index       <= '0;
              found_key   <= '0;
              found_score <= '0;
              found_age   <= '0;
              count       <= cnt_wide[3:0];
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          step    <= last_step ? '0 : step + SW'(1);
          res_rec <= res_rec_next;
          res_idx <= res_idx_next;
          found   <= found_next;
          if (last_step) begin
            pass <= 1'b1;
          end
          // last entry is picked up on the first turn of a move-last remove
          if (swap && !pass && step_eq_last) begin
            hold <= head;
          end
          if (final_edge) begin
            state       <= S_IDLE;
            done        <= 1'b1;
            cnt         <= cnt_after;
            count       <= cnt_after_wide[3:0];
            status      <= found_next ? krt_pkg::ST_OK : krt_pkg::ST_NONE;
            index       <= found_next ? idx_wide[2:0] : 3'b000;
            found_key   <= found_next ? res_rec_next.key : 16'h0000;
            found_score <= found_next ? res_rec_next.score : 8'h00;
            found_age   <= found_next ? res_rec_next.age : 8'h00;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= CW'(DEPTH))
    else $error("fill count beyond table depth");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while still scanning");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != krt_pkg::ST_OK)) |->
      (index == 3'b000 && found_key == 16'h0000 && found_score == 8'h00 &&
       found_age == 8'h00))
    else $error("failed request carries a record");

  a_count_on_done: assert property (@(posedge clk) disable iff (rst)
    !$stable(count) |-> done)
    else $error("count moved without a result");
`endif

endmodule
`default_nettype wire

@@ tb/keyed_record_table_with_delete_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyed_record_table_with_delete_test
// Self-checking bench for the keyed record table. A scoreboard class keeps its
// own copy of the table and predicts status, index, record and count for every
// request taken. Directed requests cover empty and full tables, ties and
// reserved request types. Random phases then run in both remove modes with
// shifting append rates, random start gaps and a forced drain.
// ----------------------------------------------------------------------------
module keyed_record_table_with_delete_test;
  import krt_pkg::*;

  localparam int         TABLE_DEPTH     = 8;
  localparam logic [2:0] REQ_RESERVED_LO = 3'd5;
  localparam logic [2:0] REQ_RESERVED_MID = 3'd6;
  localparam logic [2:0] REQ_RESERVED_HI = 3'd7;
  localparam bit         MODE_SHIFT      = 1'b0;
  localparam bit         MODE_SWAP_LAST  = 1'b1;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] index;
    rec_t       rec;
    logic [3:0] count;
  } table_result_t;

  class table_scoreboard;
    rec_t          entries[TABLE_DEPTH];
    int unsigned   fill;
    bit            swap_last;
    table_result_t expected_q[$];
    int            mismatches;

    function new();
      fill = 0;
      swap_last = MODE_SHIFT;
      mismatches = 0;
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", what);
    endfunction

    // predict one accepted request and update the table copy
    function void note_request(logic [2:0] req, rec_t r, logic [2:0] pos);
      table_result_t res;
      int            best;
      int            i;
      res = '0;
      res.status = ST_NONE;
      case (req)
        REQ_APPEND: begin
          if (fill >= TABLE_DEPTH) begin
            res.status = ST_FULL;
          end else begin
            entries[fill] = r;
            res.status = ST_OK;
            res.index = 3'(fill);
            res.rec = r;
            fill++;
          end
        end
        REQ_FIND: begin
          for (i = 0; i < fill; i++) begin
            if (entries[i].key == r.key) begin
              res.status = ST_OK;
              res.index = 3'(i);
              res.rec = entries[i];
              break;
            end
          end
        end
        REQ_REMOVE: begin
          if (fill == 0) begin
            res.status = ST_NONE;
          end else if (pos >= fill) begin
            res.status = ST_RANGE;
          end else begin
            res.status = ST_OK;
            res.index = pos;
            res.rec = entries[pos];
            if (swap_last) begin
              entries[pos] = entries[fill - 1];
            end else begin
              for (i = pos; i + 1 < fill; i++) entries[i] = entries[i + 1];
            end
            fill--;
          end
        end
        REQ_MAX, REQ_MIN: begin
          if (fill != 0) begin
            best = 0;
            for (i = 1; i < fill; i++) begin
              if (req == REQ_MAX) begin
                if (entries[i].score >= entries[best].score) best = i;
              end else begin
                if (entries[i].score < entries[best].score) best = i;
              end
            end
            res.status = ST_OK;
            res.index = 3'(best);
            res.rec = entries[best];
          end
        end
        default: begin
          res.status = ST_NONE;
        end
      endcase
      res.count = 4'(fill);
      expected_q.push_back(res);
    endfunction

    function void check_result(table_result_t got);
      table_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with no request pending: st=%0d idx=%0d cnt=%0d",
                         got.status, got.index, got.count));
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status || got.index !== want.index ||
          got.rec.key !== want.rec.key || got.rec.score !== want.rec.score ||
          got.rec.age !== want.rec.age || got.count !== want.count) begin
        report($sformatf({"exp st=%0d idx=%0d key=%h score=%h age=%h cnt=%0d, ",
                          "got st=%0d idx=%0d key=%h score=%h age=%h cnt=%0d"},
                         want.status, want.index, want.rec.key, want.rec.score,
                         want.rec.age, want.count, got.status, got.index,
                         got.rec.key, got.rec.score, got.rec.age, got.count));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  req_type;
  logic [15:0] key;
  logic [7:0]  score;
  logic [7:0]  age;
  logic [2:0]  position;
  logic        done;
  logic [1:0]  status;
  logic [2:0]  index;
  logic [15:0] found_key;
  logic [7:0]  found_score;
  logic [7:0]  found_age;
  logic [3:0]  count;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;

  table_scoreboard sb;
  bit              gaps_on;

  keyed_record_table_with_delete #(
    .DEPTH(TABLE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .key(key),
    .score(score),
    .age(age),
    .position(position),
    .done(done),
    .status(status),
    .index(index),
    .found_key(found_key),
    .found_score(found_score),
    .found_age(found_age),
    .count(count),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_result('{status: status, index: index,
                        rec: '{key: found_key, score: found_score, age: found_age},
                        count: count});
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // drive one item at the falling edge and hold it until busy is low
  task automatic send_request(logic [2:0] req, logic [15:0] k, logic [7:0] sc,
                              logic [7:0] ag, logic [2:0] pos, int gap);
    req_type = req;
    key = k;
    score = sc;
    age = ag;
    position = pos;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(req, '{key: k, score: sc, age: ag}, pos);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    start = 1'b0;
    while (sb.expected_q.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic write_remove_mode(bit mode);
    drain_results();
    cfg_data = mode;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.swap_last = mode;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_random_request(int append_pct);
    logic [2:0]  req;
    logic [15:0] k;
    logic [7:0]  sc;
    logic [2:0]  pos;
    int          r;
    r = $urandom_range(0, 99);
    if (r < append_pct) begin
      req = REQ_APPEND;
    end else begin
      r = $urandom_range(0, 19);
      if (r < 7) req = REQ_FIND;
      else if (r < 13) req = REQ_REMOVE;
      else if (r < 16) req = REQ_MAX;
      else if (r < 19) req = REQ_MIN;
      else req = 3'($urandom_range(REQ_RESERVED_LO, REQ_RESERVED_HI));
    end
    // a small key pool makes find hits common
    if ($urandom_range(0, 9) < 7) k = 16'($urandom_range(0, 11) * 5461);
    else k = 16'($urandom);
    // few distinct scores force ties for max and min
    if ($urandom_range(0, 1) == 0) sc = 8'($urandom_range(0, 3) * 85);
    else sc = 8'($urandom);
    if (sb.fill > 0 && $urandom_range(0, 3) != 0) pos = 3'($urandom_range(0, sb.fill - 1));
    else pos = 3'($urandom_range(0, 7));
    send_request(req, k, sc, 8'($urandom), pos, pick_gap());
  endtask

  initial begin
    int append_mix[6];
    int phase;
    int n;
    int waited;
    append_mix = '{60, 25, 45, 70, 20, 40};
    sb = new();
    gaps_on = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    req_type = REQ_APPEND;
    key = '0;
    score = '0;
    age = '0;
    position = '0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_remove_mode(MODE_SHIFT);

    // empty table
    send_request(REQ_MAX, 16'h0000, 8'h00, 8'h00, 3'd0, 0);
    send_request(REQ_MIN, 16'h0000, 8'h00, 8'h00, 3'd0, 0);
    send_request(REQ_FIND, 16'h0000, 8'h00, 8'h00, 3'd0, 0);
    send_request(REQ_REMOVE, 16'h0000, 8'h00, 8'h00, 3'd0, 0);
    send_request(REQ_RESERVED_HI, 16'hFFFF, 8'hFF, 8'hFF, 3'd7, 0);
    // fill up with extreme fields and tied scores
    send_request(REQ_APPEND, 16'h0000, 8'hFF, 8'h00, 3'd0, 0);
    send_request(REQ_APPEND, 16'hFFFF, 8'h00, 8'hFF, 3'd7, 0);
    send_request(REQ_APPEND, 16'h1234, 8'h80, 8'h11, 3'd0, 0);
    send_request(REQ_APPEND, 16'hFFFF, 8'hFF, 8'h22, 3'd0, 0);
    send_request(REQ_APPEND, 16'h0001, 8'h00, 8'h33, 3'd0, 0);
    send_request(REQ_APPEND, 16'h8000, 8'h7F, 8'h44, 3'd0, 0);
    send_request(REQ_APPEND, 16'h00FF, 8'hFF, 8'h55, 3'd0, 0);
    send_request(REQ_APPEND, 16'hFF00, 8'h00, 8'h66, 3'd0, 0);
    send_request(REQ_MAX, 16'h0000, 8'h00, 8'h00, 3'd0, 0);
    send_request(REQ_MIN, 16'h0000, 8'h00, 8'h00, 3'd0, 0);
    send_request(REQ_APPEND, 16'hABCD, 8'h12, 8'h34, 3'd0, 0);
    send_request(REQ_FIND, 16'hFFFF, 8'h00, 8'h00, 3'd0, 0);
    send_request(REQ_FIND, 16'hFF00, 8'h00, 8'h00, 3'd0, 0);
    send_request(REQ_FIND, 16'h5555, 8'h00, 8'h00, 3'd0, 0);
    send_request(REQ_REMOVE, 16'h0000, 8'h00, 8'h00, 3'd7, 0);
    send_request(REQ_REMOVE, 16'h0000, 8'h00, 8'h00, 3'd0, 0);
    send_request(REQ_REMOVE, 16'h0000, 8'h00, 8'h00, 3'd7, 0);
    send_request(REQ_RESERVED_LO, 16'h0000, 8'h00, 8'h00, 3'd0, 0);
    send_request(REQ_RESERVED_MID, 16'h0000, 8'h00, 8'h00, 3'd0, 0);
    send_request(REQ_REMOVE, 16'h0000, 8'h00, 8'h00, 3'd5, 0);

    for (phase = 0; phase < 6; phase++) begin
      write_remove_mode((phase % 2 == 0) ? MODE_SWAP_LAST : MODE_SHIFT);
      for (n = 0; n < 300; n++) begin
        if (n % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
        if (n == 150) drain_results();
        send_random_request(append_mix[phase]);
      end
    end

    start = 1'b0;
    waited = 0;
    while (sb.expected_q.size() != 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    repeat (2 * TABLE_DEPTH + 4) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/krt_pkg.sv
rtl/krt_cell.sv
rtl/keyed_record_table_with_delete.sv
tb/keyed_record_table_with_delete_test.sv
